/* design/n2ew_pkg.sv */
// ----------------------------------------------------------------------------
// n2ew_pkg: shared types and constants for the number-to-words block
// Word codes, group arithmetic constants, controller states and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package n2ew_pkg;

    // Output token width and word codes
    localparam int WORD_W = 6;
    localparam logic [WORD_W-1:0] WORD_ZERO       = 6'd0;
    localparam logic [WORD_W-1:0] WORD_TENS_BASE  = 6'd18;
    localparam logic [WORD_W-1:0] WORD_HUNDRED    = 6'd28;
    localparam logic [WORD_W-1:0] WORD_SCALE_BASE = 6'd28;

    // Base-1000 groups: seven cover a 64-bit value
    localparam int MAX_GROUPS = 7;
    localparam int IDX_W      = $clog2(MAX_GROUPS);
    localparam int GRP_W      = 10;
    localparam logic [GRP_W:0]   GRP_BASE = 11'd1000;
    localparam logic [GRP_W-1:0] GRP_HALF = 10'd500;

    // Value bits folded into the groups per conversion cycle
    localparam int STEP_BITS = 4;

    // Digit split widths and reciprocal constants
    localparam int HUND_W = 4;
    localparam int REM_W  = 7;
    localparam int DIG_W  = 4;
    localparam logic [GRP_W-1:0] GRP_HUNDRED = 10'd100;
    localparam logic [5:0]       RECIP_100   = 6'd41;   // 41 / 2^12 ~ 1/100
    localparam int               RECIP_100_SH = 12;
    localparam logic [6:0]       RECIP_10    = 7'd103;  // 103 / 2^10 ~ 1/10
    localparam int               RECIP_10_SH = 10;
    localparam logic [REM_W-1:0] REM_TEN     = 7'd10;
    localparam logic [REM_W-1:0] REM_TWENTY  = 7'd20;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV,
        ST_CHECK,
        ST_ZERO,
        ST_SEEK,
        ST_HDIGIT,
        ST_HWORD,
        ST_TENS,
        ST_UNITS,
        ST_SCALE
    } state_t;

    // Which word the datapath puts in the output register
    typedef enum logic [2:0] {
        WSEL_ZERO,
        WSEL_HDIGIT,
        WSEL_HUNDRED,
        WSEL_TEEN,
        WSEL_TENS,
        WSEL_UNITS,
        WSEL_SCALE
    } wsel_t;

    typedef struct packed {
        logic  load;     // take a new value, clear groups
        logic  conv;     // fold the next bits into the groups
        logic  shift;    // move the next lower group to the top
        logic  decode;   // split the top group into hundreds and rest
        logic  emit;     // load the output register
        logic  last;     // last flag of the emitted item
        wsel_t wsel;
    } dp_cmd_t;

    typedef struct packed {
        logic conv_done;
        logic all_zero;
        logic top_zero;
        logic top_hund;
        logic lower_zero;
        logic idx_zero;
        logic r_zero;
        logic r_teen;
        logic u_zero;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

/* design/number_to_english_words.sv */
// ----------------------------------------------------------------------------
// number_to_english_words: English name of an unsigned value as word items
// One input item (value) gives a run of output items (word, last), one word
// per item, most significant group first; last marks the final word.
// Usage:
//  - Input channel in_valid/in_stall/value. A value is taken when in_valid
//    is high and in_stall low; in_stall is high while a value is worked on.
//  - Output channel out_valid/out_stall/word/last. One output register holds
//    the word being offered; the next value is taken while the final word of
//    the previous one still waits in it.
//  - Sequence: shift-and-double conversion (four bits per cycle), a check
//    state, then per group visited a seek step that skips or decodes it and
//    one emit step per word; a zero value goes from the check state to its
//    single word. A value is named in up to 31 words at VALUE_BITS = 64.
//  - A stalled receiver holds the current word and the sequencer waits.
//  - Reset clears the controller and the output valid; no value is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module number_to_english_words
    import n2ew_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [VALUE_BITS-1:0] value,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [WORD_W-1:0]          word,
    output logic                       last
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer
    n2ew_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Group conversion, digit split and output register
    n2ew_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .stat      (stat),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .word      (word),
        .last      (last)
    );

endmodule

`default_nettype wire

/* design/n2ew_dp.sv */
// ----------------------------------------------------------------------------
// n2ew_dp: datapath of the number-to-words block
// Converts the value into base-1000 groups by shift-and-double, splits the
// top group into digits and holds the output item register.
// ----------------------------------------------------------------------------
`default_nettype none

module n2ew_dp
    import n2ew_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [VALUE_BITS-1:0] value,
    input  wire dp_cmd_t               cmd,
    output dp_stat_t                   stat,
    input  wire logic                  out_stall,
    output logic                       out_valid,
    output logic [WORD_W-1:0]          word,
    output logic                       last
);

    localparam int PAD_BITS   = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
    localparam int CONV_STEPS = PAD_BITS / STEP_BITS;
    localparam int CNT_W      = $clog2(CONV_STEPS);

    logic [PAD_BITS-1:0] bits_reg, bits_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [GRP_W-1:0]    grp_reg [MAX_GROUPS];
    logic [GRP_W-1:0]    grp_next [MAX_GROUPS];
    logic [GRP_W-1:0]    grp_dbl [MAX_GROUPS];
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [HUND_W-1:0]   h_reg;
    logic [REM_W-1:0]    r_reg;

    logic [15:0]         prod_h;
    logic [HUND_W-1:0]   h_dec;
    logic [GRP_W-1:0]    r_dec;
    logic [13:0]         prod_t;
    logic [DIG_W-1:0]    tens_dig;
    logic [REM_W-1:0]    units_full;
    logic [DIG_W-1:0]    units_dig;
    logic [WORD_W-1:0]   word_sel;
    logic                lower_zero;

    logic                valid_reg, valid_next;
    logic [WORD_W-1:0]   word_reg;
    logic                last_reg;

    // Fold STEP_BITS value bits, MSB first, into the groups by doubling.
    // The carry out of a group depends only on its old value being >= 500.
    always_comb
    begin
        logic [GRP_W-1:0] tmp   [MAX_GROUPS];
        logic             carry [MAX_GROUPS];
        logic [GRP_W:0]   sum;
        tmp = grp_reg;
        sum = '0;
        for (int s = 0; s < STEP_BITS; s++)
        begin
            for (int i = 0; i < MAX_GROUPS; i++)
            begin
                if (i == 0)
                    carry[i] = bits_reg[PAD_BITS-1-s];
                else
                    carry[i] = (tmp[i-1] >= GRP_HALF);
            end
            for (int i = 0; i < MAX_GROUPS; i++)
            begin
                sum = {tmp[i], carry[i]};
                if (sum >= GRP_BASE)
                    sum = sum - GRP_BASE;
                tmp[i] = sum[GRP_W-1:0];
            end
        end
        grp_dbl = tmp;
    end

    // Next values of value shifter, step counter, groups and scale index
    always_comb
    begin
        bits_next = bits_reg;
        cnt_next  = cnt_reg;
        grp_next  = grp_reg;
        idx_next  = idx_reg;
        if (cmd.load)
        begin
            bits_next = PAD_BITS'(value);
            cnt_next  = '0;
            idx_next  = IDX_W'(MAX_GROUPS - 1);
            for (int i = 0; i < MAX_GROUPS; i++)
                grp_next[i] = '0;
        end
        else if (cmd.conv)
        begin
            bits_next = bits_reg << STEP_BITS;
            cnt_next  = cnt_reg + 1'b1;
            grp_next  = grp_dbl;
        end
        else if (cmd.shift)
        begin
            for (int i = MAX_GROUPS - 1; i > 0; i--)
                grp_next[i] = grp_reg[i-1];
            grp_next[0] = '0;
            idx_next    = idx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        grp_reg  <= grp_next;
    end

    // Split the top group: hundreds digit and remainder below 100
    assign prod_h = 16'(grp_reg[MAX_GROUPS-1]) * 16'(RECIP_100);
    assign h_dec  = prod_h[RECIP_100_SH +: HUND_W];
    assign r_dec  = grp_reg[MAX_GROUPS-1] - GRP_W'(h_dec) * GRP_HUNDRED;

    always_ff @(posedge clk)
    begin
        if (cmd.decode)
        begin
            h_reg <= h_dec;
            r_reg <= r_dec[REM_W-1:0];
        end
    end

    // Tens and units digits of the remainder
    assign prod_t     = 14'(r_reg) * 14'(RECIP_10);
    assign tens_dig   = prod_t[RECIP_10_SH +: DIG_W];
    assign units_full = r_reg - REM_W'(tens_dig) * REM_TEN;
    assign units_dig  = units_full[DIG_W-1:0];

    // Pick the word code for the item being emitted
    always_comb
    begin
        unique case (cmd.wsel)
            WSEL_ZERO:    word_sel = WORD_ZERO;
            WSEL_HDIGIT:  word_sel = WORD_W'(h_reg);
            WSEL_HUNDRED: word_sel = WORD_HUNDRED;
            WSEL_TEEN:    word_sel = WORD_W'(r_reg);
            WSEL_TENS:    word_sel = WORD_TENS_BASE + WORD_W'(tens_dig);
            WSEL_UNITS:   word_sel = WORD_W'(units_dig);
            WSEL_SCALE:   word_sel = WORD_SCALE_BASE + WORD_W'(idx_reg);
            default:      word_sel = WORD_ZERO;
        endcase
    end

    // Output item register: load on emit, drop when taken
    always_comb
    begin
        valid_next = valid_reg && out_stall;
        if (cmd.emit)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            word_reg <= word_sel;
            last_reg <= cmd.last;
        end
    end

    // Status toward the controller
    always_comb
    begin
        lower_zero = 1'b1;
        for (int i = 0; i < MAX_GROUPS - 1; i++)
            if (grp_reg[i] != '0)
                lower_zero = 1'b0;
    end

    assign stat.conv_done  = (cnt_reg == CNT_W'(CONV_STEPS - 1));
    assign stat.top_zero   = (grp_reg[MAX_GROUPS-1] == '0);
    assign stat.top_hund   = (grp_reg[MAX_GROUPS-1] >= GRP_HUNDRED);
    assign stat.lower_zero = lower_zero;
    assign stat.all_zero   = lower_zero && stat.top_zero;
    assign stat.idx_zero   = (idx_reg == '0);
    assign stat.r_zero     = (r_reg == '0);
    assign stat.r_teen     = (r_reg < REM_TWENTY);
    assign stat.u_zero     = (units_dig == '0);
    assign stat.out_free   = !valid_reg || !out_stall;

    assign out_valid = valid_reg;
    assign word      = word_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

/* design/n2ew_ctrl.sv */
// ----------------------------------------------------------------------------
// n2ew_ctrl: controller of the number-to-words block
// Sequences conversion, group search and the word items of each group.
// ----------------------------------------------------------------------------
`default_nettype none

module n2ew_ctrl
    import n2ew_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.wsel   = WSEL_ZERO;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv = 1'b1;
                if (stat.conv_done)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = stat.all_zero ? ST_ZERO : ST_SEEK;
            end
            ST_ZERO:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    cmd.wsel   = WSEL_ZERO;
                    state_next = ST_IDLE;
                end
            end
            ST_SEEK:
            begin
                // skip zero groups, split the first nonzero one
                if (stat.top_zero)
                    cmd.shift = 1'b1;
                else
                begin
                    cmd.decode = 1'b1;
                    state_next = stat.top_hund ? ST_HDIGIT : ST_TENS;
                end
            end
            ST_HDIGIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.wsel   = WSEL_HDIGIT;
                    state_next = ST_HWORD;
                end
            end
            ST_HWORD:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.wsel = WSEL_HUNDRED;
                    cmd.last = stat.r_zero && stat.idx_zero;
                    if (!stat.r_zero)
                        state_next = ST_TENS;
                    else
                        state_next = stat.idx_zero ? ST_IDLE : ST_SCALE;
                end
            end
            ST_TENS:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.r_teen)
                    begin
                        cmd.wsel   = WSEL_TEEN;
                        cmd.last   = stat.idx_zero;
                        state_next = stat.idx_zero ? ST_IDLE : ST_SCALE;
                    end
                    else
                    begin
                        cmd.wsel = WSEL_TENS;
                        cmd.last = stat.u_zero && stat.idx_zero;
                        if (!stat.u_zero)
                            state_next = ST_UNITS;
                        else
                            state_next = stat.idx_zero ? ST_IDLE : ST_SCALE;
                    end
                end
            end
            ST_UNITS:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.wsel   = WSEL_UNITS;
                    cmd.last   = stat.idx_zero;
                    state_next = stat.idx_zero ? ST_IDLE : ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.wsel = WSEL_SCALE;
                    cmd.last = stat.lower_zero;
                    if (stat.lower_zero)
                        state_next = ST_IDLE;
                    else
                    begin
                        cmd.shift  = 1'b1;
                        state_next = ST_SEEK;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* verif/number_to_english_words_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// number_to_english_words_test: self-checking bench for the number namer
// Feeds 64-bit values through the valid/stall input channel and checks every
// word token that comes back against a local naming predictor. A short
// directed table covers the word classes and value extremes; random values,
// mostly built from base-1000 groups, follow under three idle/stall regimes.
// ----------------------------------------------------------------------------
`default_nettype none

module number_to_english_words_test;
    import n2ew_pkg::*;

    localparam int NAME_BITS   = 64;
    localparam int RANDOM_A    = 70;      // random values in the first regime
    localparam int RANDOM_B    = 90;
    localparam int RANDOM_C    = 100;
    localparam int DRAIN_TICKS = 80;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int REPORT_MAX  = 10;

    // Plain units codes used in the directed rows
    localparam logic [WORD_W-1:0] WORD_ONE      = 6'd1;
    localparam logic [WORD_W-1:0] WORD_NINETEEN = 6'd19;

    typedef struct packed {
        logic [WORD_W-1:0] code;
        logic              fin;
    } word_tok_t;

    typedef struct packed {
        logic [63:0]       num;
        logic              typed;    // single-word name typed in below
        logic [WORD_W-1:0] code;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [NAME_BITS-1:0] value     = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [WORD_W-1:0]    word;
    logic                 last;

    word_tok_t   pending_words[$];
    dir_row_t    directed_rows[24];
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          bad_count      = 0;
    int          values_named   = 0;
    int          words_checked  = 0;
    int          longest_name   = 0;
    int          cycle_count    = 0;

    number_to_english_words #(
        .VALUE_BITS (NAME_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .word      (word),
        .last      (last)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Guard against a hung handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still owed",
                     cycle_count, pending_words.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Name a value as word tokens and queue them
    function automatic void name_value(input logic [63:0] raw);
        logic [63:0]       v;
        int unsigned       grp[MAX_GROUPS];
        int unsigned       g;
        int unsigned       rest;
        int                n;
        word_tok_t         toks[$];
        logic [63:0]       keep;

        keep = (NAME_BITS >= 64) ? '1 : ((64'd1 << NAME_BITS) - 64'd1);
        v = raw & keep;
        n = 0;
        if (v == 64'd0)
            toks.push_back('{WORD_ZERO, 1'b0});
        while (v != 64'd0 && n < MAX_GROUPS)
        begin
            grp[n] = int'(v % 64'd1000);
            v      = v / 64'd1000;
            n++;
        end
        for (int j = n - 1; j >= 0; j--)
        begin
            g = grp[j];
            if (g == 0)
                continue;
            rest = g % 100;
            if (g >= 100)
            begin
                toks.push_back('{WORD_W'(g / 100), 1'b0});
                toks.push_back('{WORD_HUNDRED, 1'b0});
            end
            if (rest != 0 && rest < 20)
                toks.push_back('{WORD_W'(rest), 1'b0});
            else if (rest >= 20)
            begin
                toks.push_back('{WORD_TENS_BASE + WORD_W'(rest / 10), 1'b0});
                if (rest % 10 != 0)
                    toks.push_back('{WORD_W'(rest % 10), 1'b0});
            end
            if (j > 0)
                toks.push_back('{WORD_SCALE_BASE + WORD_W'(j), 1'b0});
        end
        toks[toks.size() - 1].fin = 1'b1;
        if (toks.size() > longest_name)
            longest_name = toks.size();
        foreach (toks[i])
            pending_words.push_back(toks[i]);
    endfunction

    // Draw a value: mostly group-structured, some raw bits, some small
    function automatic logic [63:0] pick_value();
        int unsigned  kind;
        int unsigned  ngrp;
        int unsigned  g;
        logic [127:0] acc;

        kind = $urandom_range(99);
        if (kind < 25)
            return {$urandom, $urandom};
        if (kind < 35)
            return 64'($urandom_range(1000));
        ngrp = $urandom_range(MAX_GROUPS, 1);
        acc  = '0;
        for (int j = ngrp - 1; j >= 0; j--)
        begin
            case ($urandom_range(5))
                0:       g = 0;
                1:       g = $urandom_range(19);
                2:       g = $urandom_range(9) * 100;
                3:       g = $urandom_range(9) * 100 + $urandom_range(9) * 10;
                default: g = $urandom_range(999);
            endcase
            if (j == MAX_GROUPS - 1)
                g = g % 19;
            acc = acc * 128'd1000 + 128'(g);
        end
        return acc[63:0];
    endfunction

    // Offer one value, hold it until taken, then predict its words
    task automatic send_value(input logic [63:0] v, input logic typed,
                              input logic [WORD_W-1:0] code);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        value    <= v[NAME_BITS-1:0];
        do
            @(posedge clk);
        while (in_stall);
        values_named++;
        if (typed)
            pending_words.push_back('{code, 1'b1});
        else
            name_value(v);
    endtask

    task automatic report_bad(input string what, input word_tok_t want,
                              input word_tok_t got);
        bad_count++;
        if (bad_count <= REPORT_MAX)
            $display("%0t %s: expected word %0d last %0b, got word %0d last %0b",
                     $realtime, what, want.code, want.fin, got.code, got.fin);
    endtask

    // Check each accepted word, then pick the next stall
    always @(posedge clk)
    begin
        word_tok_t got;
        word_tok_t want;

        if (rst_n && out_valid && !out_stall)
        begin
            got = '{word, last};
            words_checked++;
            if (pending_words.size() == 0)
                report_bad("unexpected word", '0, got);
            else
            begin
                want = pending_words.pop_front();
                if (got.code !== want.code || got.fin !== want.fin)
                    report_bad("word mismatch", want, got);
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Stimulus and verdict
    initial
    begin
        directed_rows = '{
            '{64'd0,                    1'b1, WORD_ZERO},
            '{64'd1,                    1'b1, WORD_ONE},
            '{64'd19,                   1'b1, WORD_NINETEEN},
            '{64'd20,                   1'b1, WORD_TENS_BASE + 6'd2},
            '{64'd90,                   1'b1, WORD_TENS_BASE + 6'd9},
            '{64'd13,                   1'b0, WORD_ZERO},
            '{64'd21,                   1'b0, WORD_ZERO},
            '{64'd99,                   1'b0, WORD_ZERO},
            '{64'd100,                  1'b0, WORD_ZERO},
            '{64'd101,                  1'b0, WORD_ZERO},
            '{64'd110,                  1'b0, WORD_ZERO},
            '{64'd119,                  1'b0, WORD_ZERO},
            '{64'd999,                  1'b0, WORD_ZERO},
            '{64'd1000,                 1'b0, WORD_ZERO},
            '{64'd1001,                 1'b0, WORD_ZERO},
            '{64'd1000000,              1'b0, WORD_ZERO},
            '{64'd100010001000,         1'b0, WORD_ZERO},
            '{64'd1000000000000000000,  1'b0, WORD_ZERO},
            '{64'd1000000000000000001,  1'b0, WORD_ZERO},
            '{64'd17777777777777777777, 1'b0, WORD_ZERO},
            '{64'hFFFF_FFFF_FFFF_FFFF,  1'b0, WORD_ZERO},
            '{64'h8000_0000_0000_0000,  1'b0, WORD_ZERO},
            '{64'h5555_5555_5555_5555,  1'b0, WORD_ZERO},
            '{64'hAAAA_AAAA_AAAA_AAAA,  1'b0, WORD_ZERO}
        };

        // Hold reset, then release it
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Mostly busy sender, heavily stalled receiver
        send_idle_pct  = 25;
        recv_stall_pct = 87;
        foreach (directed_rows[i])
            send_value(directed_rows[i].num, directed_rows[i].typed,
                       directed_rows[i].code);
        repeat (RANDOM_A) send_value(pick_value(), 1'b0, WORD_ZERO);

        // Mostly idle sender, lightly stalled receiver
        send_idle_pct  = 87;
        recv_stall_pct = 25;
        repeat (RANDOM_B) send_value(pick_value(), 1'b0, WORD_ZERO);

        // Full rate both ways
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (RANDOM_C) send_value(pick_value(), 1'b0, WORD_ZERO);
        in_valid <= 1'b0;

        // Drain outstanding words, then watch for strays
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TICKS) @(posedge clk);

        $display("named %0d values as %0d words, longest name %0d words",
                 values_named, words_checked, longest_name);
        $display("regimes: sender idle 25/87/0 pct, receiver stall 87/25/0 pct");
        if (bad_count == 0 && pending_words.size() == 0)
            $display("[ OK ] regression clean");
        else
        begin
            $display("%0d bad words, %0d words never seen",
                     bad_count, pending_words.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
